// ===== sv/pce_pkg.sv =====
// pce_pkg: shared types, constants and helpers of the punycode label encoder
// used by pce_front, pce_div, pce_back and punycode_label_encoder
package pce_pkg;

    localparam int CP_W    = 21;
    localparam int CHAR_W  = 7;
    localparam int LEN_W   = 6;
    localparam int DELTA_W = 32;
    localparam int DIV_W   = 10;
    localparam int N_W     = 22;
    localparam int BIAS_W  = 8;
    localparam int K_W     = 10;
    localparam int T_W     = 5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_LONG = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    localparam logic [K_W-1:0]    BASE         = 10'd36;
    localparam logic [T_W-1:0]    TMIN         = 5'd1;
    localparam logic [T_W-1:0]    TMAX         = 5'd26;
    localparam logic [DIV_W-1:0]  SKEW         = 10'd38;
    localparam logic [DELTA_W-1:0] ADAPT_LIMIT = 32'd455;
    localparam logic [BIAS_W-1:0] BIAS_START   = 8'd72;
    localparam logic [N_W-1:0]    N_START      = 22'd128;
    localparam logic [CP_W-1:0]   BASIC_LIMIT  = 21'h80;
    localparam logic [CHAR_W-1:0] HYPHEN       = 7'h2d;
    localparam logic [LEN_W-1:0]  MAX_OUT      = 6'd63;
    localparam logic [LEN_W-1:0]  LEN_RESET    = 6'd63;

    // x / 700 == (x * RECIP_DAMP) >> DAMP_SH and x / 35 == (x * RECIP_ADAPT) >> ADAPT_SH,
    // exact for every 32-bit x
    localparam logic [32:0]       RECIP_DAMP   = 33'd6282923588;
    localparam int                DAMP_SH      = 42;
    localparam logic [32:0]       RECIP_ADAPT  = 33'd7853654485;
    localparam int                ADAPT_SH     = 38;

    typedef enum logic [4:0] {
        S_IDLE, S_B_RD, S_B_CHK, S_HYPH, S_LOOP, S_M_RD, S_M_CHK, S_DELTA, S_DADD,
        S_S_RD, S_S_CHK, S_T, S_T_DIV, S_BIAS0, S_A1, S_A1W, S_A2,
        S_A3W, S_END_ROUND, S_DONE, S_ERR, S_O_RD, S_O_LD, S_O_WAIT
    } enc_state_t;

    typedef struct packed {
        logic                 start;
        logic [DELTA_W-1:0]   dividend;
        logic [DIV_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DELTA_W-1:0]   quot;
        logic [DIV_W-1:0]     rem;
    } div_rsp_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        if (v < 6'd26)
            c = 7'd97 + 7'(v);
        else
            c = 7'd48 + 7'(v - 6'd26);
        return c;
    endfunction

endpackage

// ===== sv/punycode_label_encoder.sv =====
// punycode_label_encoder: loads one code point item per cycle while in_stall is low, then
// encodes the label for N points: a basic pass, then rounds; each output digit except the last
// of each delta takes a divide on pce_div, each bias adaptation two divides on pce_div;
// then the result items go out; the next label loads meanwhile
// rst_n is asynchronous, active low: clears control state and sets max_output_length to 63;
// the point store and output buffer hold no reset, only written entries are ever read
module punycode_label_encoder #(
    parameter int MAX_POINTS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic [pce_pkg::CP_W-1:0]   code_point,
    input  logic                       last_item,
    input  logic                       in_valid,
    output logic                       in_stall,
    output logic [pce_pkg::CHAR_W-1:0] out_char,
    output logic                       last_char,
    output logic [1:0]                 status,
    output logic                       out_valid,
    input  logic                       out_stall
);
    import pce_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    logic [LEN_W-1:0] max_len_reg;
    logic             q_push, q_pop, q_not_empty, q_full, back_busy;
    logic [CW:0]      q_din, q_dout;
    logic [AW-1:0]    rd_addr;
    logic [CP_W-1:0]  rd_data;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {26'd0, max_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= LEN_RESET;
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            max_len_reg <= pwdata[LEN_W-1:0];
    end

    pce_front #(.MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .code_point  (code_point),
        .last_item   (last_item),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .back_busy   (back_busy || q_full),
        .q_not_empty (q_not_empty),
        .q_push      (q_push),
        .q_din       (q_din),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    pce_fifo #(.W(CW + 1)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    pce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pce_back #(.MAX_POINTS(MAX_POINTS), .CW(CW), .AW(AW)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_len     (max_len_reg),
        .q_not_empty (q_not_empty),
        .q_dout      (q_dout),
        .q_pop       (q_pop),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .busy        (back_busy),
        .out_char    (out_char),
        .last_char   (last_char),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall)
    );
endmodule

// ===== sv/pce_fifo.sv =====
// pce_fifo: two-entry queue of label descriptors between front and back
// depends on nothing but its width parameter
module pce_fifo #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         not_empty,
    output logic         full
);
    logic [W-1:0] slot_reg [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   fill_reg;

    assign dout      = slot_reg[rd_ptr_reg];
    assign not_empty = (fill_reg != 2'd0);
    assign full      = (fill_reg == 2'd2);

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop && not_empty)
                rd_ptr_reg <= ~rd_ptr_reg;
            fill_reg <= fill_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
        end
    end
endmodule

// ===== sv/pce_front.sv =====
// pce_front: accepts code point items, writes the point store, tracks overflow
// depends on pce_pkg; pushes one descriptor per label into pce_fifo
module pce_front #(
    parameter int MAX_POINTS = 64,
    parameter int CW = $clog2(MAX_POINTS + 1),
    parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [pce_pkg::CP_W-1:0] code_point,
    input  logic                     last_item,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     back_busy,
    input  logic                     q_not_empty,
    output logic                     q_push,
    output logic [CW:0]              q_din,
    input  logic [AW-1:0]            rd_addr,
    output logic [pce_pkg::CP_W-1:0] rd_data
);
    import pce_pkg::*;

    logic [CP_W-1:0] store [MAX_POINTS];
    logic [CP_W-1:0] rd_data_reg;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            accept, has_room;

    // the store belongs to the back while it encodes or a label waits
    assign in_stall = back_busy || q_not_empty;
    assign accept   = in_valid && !in_stall;
    assign has_room = (count_reg < CW'(MAX_POINTS));
    assign rd_data  = rd_data_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        q_push     = 1'b0;
        q_din      = {ovf_reg || !has_room, has_room ? count_reg + CW'(1) : count_reg};
        if (accept)
        begin
            if (has_room)
                count_next = count_reg + CW'(1);
            else
                ovf_next = 1'b1;
            if (last_item)
            begin
                q_push     = 1'b1;
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_room)
            store[count_reg[AW-1:0]] <= code_point;
        rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule

// ===== sv/pce_div.sv =====
// pce_div: shared restoring divider, one quotient bit per cycle
// depends on pce_pkg for the request and response structs
module pce_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pce_pkg::div_req_t req,
    output pce_pkg::div_rsp_t rsp
);
    import pce_pkg::*;

    logic [DELTA_W-1:0] q_reg;
    logic [DIV_W-1:0]   r_reg, dv_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic [DIV_W:0]     shifted;
    logic               ge;

    assign shifted  = {r_reg, q_reg[DELTA_W-1]};
    assign ge       = (shifted >= {1'b0, dv_reg});
    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;
    assign rsp.rem  = r_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg  <= req.dividend;
            r_reg  <= '0;
            dv_reg <= req.divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            r_reg <= ge ? DIV_W'(shifted - {1'b0, dv_reg}) : shifted[DIV_W-1:0];
            q_reg <= {q_reg[DELTA_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= 6'(DELTA_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_reg  <= cnt_reg - 6'd1;
            done_reg <= (cnt_reg == 6'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end
endmodule

// ===== sv/pce_back.sv =====
// pce_back: encoding sequencer, output buffer and output register
// depends on pce_pkg; reads the point store in pce_front, uses pce_div
module pce_back #(
    parameter int MAX_POINTS = 64,
    parameter int CW = $clog2(MAX_POINTS + 1),
    parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pce_pkg::LEN_W-1:0]  max_len,
    input  logic                       q_not_empty,
    input  logic [CW:0]                q_dout,
    output logic                       q_pop,
    output logic [AW-1:0]              rd_addr,
    input  logic [pce_pkg::CP_W-1:0]   rd_data,
    output pce_pkg::div_req_t          div_req,
    input  pce_pkg::div_rsp_t          div_rsp,
    output logic                       busy,
    output logic [pce_pkg::CHAR_W-1:0] out_char,
    output logic                       last_char,
    output logic [1:0]                 status,
    output logic                       out_valid,
    input  logic                       out_stall
);
    import pce_pkg::*;

    enc_state_t state_reg, state_next;

    logic [CW-1:0]      cnt_reg, cnt_next, i_reg, i_next;
    logic [CW-1:0]      basic_reg, basic_next, handled_reg, handled_next;
    logic [N_W-1:0]     n_reg, n_next;
    logic [CP_W-1:0]    m_reg, m_next;
    logic               found_reg, found_next;
    logic [DELTA_W-1:0] delta_reg, delta_next, prod_reg, prod_next;
    logic [DELTA_W-1:0] q_reg, q_next, d_reg, d_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [BIAS_W-1:0]  bias_reg, bias_next, kb_reg, kb_next;
    logic [LEN_W-1:0]   emitted_reg, emitted_next, j_reg, j_next;
    logic [1:0]         err_reg, err_next;
    logic               ov_reg, ov_next, lc_reg, lc_next;
    logic [CHAR_W-1:0]  oc_reg, oc_next;
    logic [1:0]         st_reg, st_next;

    logic [CHAR_W-1:0]  obuf [64];
    logic [CHAR_W-1:0]  obuf_q;

    logic               put_en, full, scan_last, q_lt_t, first;
    logic [CHAR_W-1:0]  put_val;
    logic [T_W-1:0]     t_val;
    logic [N_W-1:0]     mdiff;
    logic [DIV_W-1:0]   hp1;
    logic [2*DELTA_W:0] damp_prod, adapt_prod;

    assign rd_addr   = i_reg[AW-1:0];
    assign out_char  = oc_reg;
    assign last_char = lc_reg;
    assign status    = st_reg;
    assign out_valid = ov_reg;
    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign busy      = !(state_reg == S_IDLE || state_reg == S_ERR || state_reg == S_O_RD
                         || state_reg == S_O_LD || state_reg == S_O_WAIT);

    assign full      = (emitted_reg >= max_len) || (emitted_reg == MAX_OUT);
    assign scan_last = ((i_reg + CW'(1)) == cnt_reg);
    assign q_lt_t    = (q_reg < DELTA_W'(t_val));
    assign first     = (handled_reg == basic_reg);
    assign mdiff     = {1'b0, m_reg} - n_reg;
    assign hp1       = DIV_W'(handled_reg) + DIV_W'(1);

    // constant divides by 700 and 35 as reciprocal multiplies
    assign damp_prod  = (2*DELTA_W+1)'(delta_reg) * (2*DELTA_W+1)'(RECIP_DAMP);
    assign adapt_prod = (2*DELTA_W+1)'(d_reg) * (2*DELTA_W+1)'(RECIP_ADAPT);

    // threshold from k and bias, clamped to tmin..tmax
    always_comb
    begin
        if (k_reg <= K_W'(bias_reg))
            t_val = TMIN;
        else if (k_reg >= K_W'(bias_reg) + K_W'(TMAX))
            t_val = TMAX;
        else
            t_val = T_W'(k_reg - K_W'(bias_reg));
    end

    // character writes into the output buffer
    always_comb
    begin
        put_en  = 1'b0;
        put_val = '0;
        case (state_reg)
            S_B_CHK:
            begin
                put_en  = (rd_data < BASIC_LIMIT);
                put_val = rd_data[CHAR_W-1:0];
            end
            S_HYPH:
            begin
                put_en  = (basic_reg != '0);
                put_val = HYPHEN;
            end
            S_T:
            begin
                put_en  = q_lt_t;
                put_val = digit_char(q_reg[5:0]);
            end
            S_T_DIV:
            begin
                put_en  = div_rsp.done;
                put_val = digit_char(6'(t_val) + 6'(div_rsp.rem));
            end
            default:
            begin
                put_en  = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (q_not_empty) state_next = q_dout[CW] ? S_ERR : S_B_RD;
            S_B_RD:      state_next = S_B_CHK;
            S_B_CHK:     state_next = scan_last ? S_HYPH : S_B_RD;
            S_HYPH:      state_next = S_LOOP;
            S_LOOP:      state_next = (handled_reg < cnt_reg) ? S_M_RD : S_DONE;
            S_M_RD:      state_next = S_M_CHK;
            S_M_CHK:     state_next = scan_last ? S_DELTA : S_M_RD;
            S_DELTA:     state_next = found_reg ? S_DADD : S_DONE;
            S_DADD:      state_next = S_S_RD;
            S_S_RD:      state_next = S_S_CHK;
            S_S_CHK:
            begin
                if (rd_data == m_reg)
                    state_next = S_T;
                else
                    state_next = scan_last ? S_END_ROUND : S_S_RD;
            end
            S_T:         state_next = q_lt_t ? S_BIAS0 : S_T_DIV;
            S_T_DIV:     if (div_rsp.done) state_next = S_T;
            S_BIAS0:     state_next = S_A1;
            S_A1:        state_next = S_A1W;
            S_A1W:       if (div_rsp.done) state_next = S_A2;
            S_A2:        state_next = (d_reg > ADAPT_LIMIT) ? S_A2 : S_A3W;
            S_A3W:
            begin
                if (div_rsp.done)
                    state_next = (i_reg == cnt_reg) ? S_END_ROUND : S_S_RD;
            end
            S_END_ROUND: state_next = S_LOOP;
            S_DONE:      state_next = (emitted_reg == '0) ? S_ERR : S_O_RD;
            S_ERR:       state_next = S_O_WAIT;
            S_O_RD:      state_next = S_O_LD;
            S_O_LD:      state_next = S_O_WAIT;
            S_O_WAIT:    if (!out_stall) state_next = lc_reg ? S_IDLE : S_O_RD;
            default:     state_next = S_IDLE;
        endcase
        // a character past the limit ends the label with an error
        if (put_en && full)
            state_next = S_ERR;
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        basic_next   = basic_reg;
        handled_next = handled_reg;
        n_next       = n_reg;
        m_next       = m_reg;
        found_next   = found_reg;
        delta_next   = delta_reg;
        prod_next    = prod_reg;
        q_next       = q_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        bias_next    = bias_reg;
        kb_next      = kb_reg;
        emitted_next = emitted_reg;
        j_next       = j_reg;
        err_next     = err_reg;
        ov_next      = ov_reg;
        lc_next      = lc_reg;
        oc_next      = oc_reg;
        st_next      = st_reg;
        div_req      = '0;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next     = q_dout[CW-1:0];
                i_next       = '0;
                basic_next   = '0;
                handled_next = '0;
                n_next       = N_START;
                delta_next   = '0;
                bias_next    = BIAS_START;
                emitted_next = '0;
                err_next     = STATUS_OVF;
            end
            S_B_CHK:
            begin
                i_next = i_reg + CW'(1);
                if (rd_data < BASIC_LIMIT)
                    basic_next = basic_reg + CW'(1);
            end
            S_HYPH:
            begin
                handled_next = basic_reg;
            end
            S_LOOP:
            begin
                i_next     = '0;
                found_next = 1'b0;
            end
            S_M_CHK:
            begin
                i_next = i_reg + CW'(1);
                if (({1'b0, rd_data} >= n_reg) && (!found_reg || rd_data < m_reg))
                begin
                    m_next     = rd_data;
                    found_next = 1'b1;
                end
            end
            S_DELTA:
            begin
                prod_next = DELTA_W'(mdiff) * DELTA_W'(hp1);
                n_next    = {1'b0, m_reg};
            end
            S_DADD:
            begin
                delta_next = delta_reg + prod_reg;
                i_next     = '0;
            end
            S_S_CHK:
            begin
                i_next = i_reg + CW'(1);
                if (rd_data < m_reg)
                    delta_next = delta_reg + DELTA_W'(1);
                else if (rd_data == m_reg)
                begin
                    q_next = delta_reg;
                    k_next = BASE;
                end
            end
            S_T:
            begin
                if (!q_lt_t)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = q_reg - DELTA_W'(t_val);
                    div_req.divisor  = BASE - K_W'(t_val);
                end
            end
            S_T_DIV:
            begin
                if (div_rsp.done)
                begin
                    q_next = div_rsp.quot;
                    k_next = k_reg + BASE;
                end
            end
            S_BIAS0:
            begin
                if (first)
                    d_next = DELTA_W'(damp_prod >> DAMP_SH);
                else
                    d_next = delta_reg >> 1;
            end
            S_A1:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = d_reg;
                div_req.divisor  = hp1;
            end
            S_A1W:
            begin
                if (div_rsp.done)
                begin
                    d_next  = d_reg + div_rsp.quot;
                    kb_next = '0;
                end
            end
            S_A2:
            begin
                if (d_reg > ADAPT_LIMIT)
                begin
                    d_next  = DELTA_W'(adapt_prod >> ADAPT_SH);
                    kb_next = kb_reg + BIAS_W'(BASE);
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = d_reg * DELTA_W'(BASE);
                    div_req.divisor  = DIV_W'(d_reg) + SKEW;
                end
            end
            S_A3W:
            begin
                if (div_rsp.done)
                begin
                    bias_next    = kb_reg + BIAS_W'(div_rsp.quot);
                    delta_next   = '0;
                    handled_next = handled_reg + CW'(1);
                end
            end
            S_END_ROUND:
            begin
                delta_next = delta_reg + DELTA_W'(1);
                n_next     = n_reg + N_W'(1);
            end
            S_DONE:
            begin
                j_next   = '0;
                err_next = STATUS_LONG;
            end
            S_ERR:
            begin
                ov_next = 1'b1;
                oc_next = '0;
                lc_next = 1'b1;
                st_next = err_reg;
            end
            S_O_LD:
            begin
                ov_next = 1'b1;
                oc_next = obuf_q;
                lc_next = (j_reg == emitted_reg - LEN_W'(1));
                st_next = STATUS_OK;
            end
            S_O_WAIT:
            begin
                if (!out_stall)
                begin
                    ov_next = 1'b0;
                    j_next  = j_reg + LEN_W'(1);
                end
            end
            default:
            begin
                ov_next = ov_reg;
            end
        endcase
        if (put_en)
        begin
            if (full)
                err_next = STATUS_LONG;
            else
                emitted_next = emitted_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_en && !full)
            obuf[emitted_reg] <= put_val;
        obuf_q <= obuf[j_reg];
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        basic_reg   <= basic_next;
        handled_reg <= handled_next;
        n_reg       <= n_next;
        m_reg       <= m_next;
        found_reg   <= found_next;
        delta_reg   <= delta_next;
        prod_reg    <= prod_next;
        q_reg       <= q_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        bias_reg    <= bias_next;
        kb_reg      <= kb_next;
        emitted_reg <= emitted_next;
        j_reg       <= j_next;
        err_reg     <= err_next;
        oc_reg      <= oc_next;
        lc_reg      <= lc_next;
        st_reg      <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// ===== dv/punycode_label_encoder_tb.sv =====
// punycode_label_encoder_tb: drives code point labels into the encoder, predicts the punycode
// characters and error results, and compares them item by item; depends on pce_pkg and the RTL
module punycode_label_encoder_tb;
    import pce_pkg::*;

    localparam int NPTS = 64;
    localparam int WATCHDOG = 200000;
    localparam logic [2:0] ADDR_MAXLEN = 3'd0;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } point_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [1:0]        st;
    } char_item_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic [CP_W-1:0] code_point;
    logic last_item, in_valid, in_stall;
    logic [CHAR_W-1:0] out_char;
    logic last_char;
    logic [1:0] status;
    logic out_valid, out_stall;

    punycode_label_encoder DUT (.*);

    // predictor state
    logic [CP_W-1:0] label_pts[NPTS];
    int unsigned label_len;
    bit label_ovf;
    int unsigned max_len;

    point_item_t pending_points[$];
    char_item_t  expected_chars[$];
    int unsigned mismatches, checked, labels_sent, idle_cycles;
    bit in_quiet, tail_mode;
    int in_gap, out_gap;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned next_bias(int unsigned d, int unsigned pts, bit first);
        int unsigned k;
        k = 0;
        d = first ? d / 700 : d >> 1;
        d += d / pts;
        while (d > 455) begin
            d /= 35;
            k += 36;
        end
        return k + (36 * d) / (d + 38);
    endfunction

    function automatic logic [CHAR_W-1:0] base36_char(int unsigned v);
        return (v < 26) ? CHAR_W'(97 + v) : CHAR_W'(48 + v - 26);
    endfunction

    // encodes the stored label and queues the expected characters
    function automatic void predict_label();
        logic [CHAR_W-1:0] buffer[$];
        bit too_long, found;
        int unsigned basic, handled, m, n, delta, bias, q, k, t, p;
        too_long = 0;
        basic = 0;
        n = 128;
        bias = 72;
        delta = 0;
        if (label_ovf) begin
            expected_chars.push_back('{0, 1'b1, STATUS_OVF});
            return;
        end
        for (int i = 0; i < label_len; i++)
            if (label_pts[i] < 'h80) begin
                if (buffer.size() >= max_len) too_long = 1;
                else buffer.push_back(CHAR_W'(label_pts[i]));
                basic++;
            end
        if (basic > 0) begin
            if (buffer.size() >= max_len) too_long = 1;
            else buffer.push_back(HYPHEN);
        end
        handled = basic;
        while (handled < label_len && !too_long) begin
            found = 0;
            m = 0;
            for (int i = 0; i < label_len; i++) begin
                p = label_pts[i];
                if (p >= n && (!found || p < m)) begin
                    m = p;
                    found = 1;
                end
            end
            if (!found) break;
            delta += (m - n) * (handled + 1);
            n = m;
            for (int i = 0; i < label_len && !too_long; i++) begin
                p = label_pts[i];
                if (p < m) delta++;
                else if (p == m) begin
                    q = delta;
                    for (k = 36;; k += 36) begin
                        if (k <= bias) t = 1;
                        else if (k >= bias + 26) t = 26;
                        else t = k - bias;
                        if (q < t) break;
                        if (buffer.size() >= max_len) too_long = 1;
                        else buffer.push_back(base36_char(t + (q - t) % (36 - t)));
                        q = (q - t) / (36 - t);
                    end
                    if (buffer.size() >= max_len) too_long = 1;
                    else buffer.push_back(base36_char(q % 36));
                    bias = next_bias(delta, handled + 1, handled == basic);
                    delta = 0;
                    handled++;
                end
            end
            delta++;
            n++;
        end
        if (too_long || buffer.size() == 0)
            expected_chars.push_back('{0, 1'b1, STATUS_LONG});
        else
            foreach (buffer[i])
                expected_chars.push_back('{buffer[i], i == buffer.size() - 1, STATUS_OK});
    endfunction

    function automatic void absorb_point(point_item_t it);
        if (label_len < NPTS) label_pts[label_len++] = it.cp;
        else label_ovf = 1;
        if (it.last) begin
            predict_label();
            label_len = 0;
            label_ovf = 0;
            labels_sent++;
        end
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            code_point <= '0;
            last_item <= 1'b0;
            in_gap = 0;
        end else begin
            if (in_valid && !in_stall) begin
                absorb_point('{code_point, last_item});
                void'(pending_points.pop_front());
            end
            if (in_valid && in_stall) begin
                // hold payload
            end else if (in_quiet || pending_points.size() == 0) begin
                in_valid <= 1'b0;
            end else if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (!tail_mode && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(1, 6) - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                code_point <= pending_points[0].cp;
                last_item <= pending_points[0].last;
            end
        end
    end

    // monitor and output stall
    always @(posedge clk or negedge rst_n) begin
        char_item_t got, want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_gap = 0;
        end else begin
            if (out_valid && !out_stall) begin
                got = '{out_char, last_char, status};
                if (expected_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected char item %h last %b status %0d",
                                 out_char, last_char, status);
                end else begin
                    want = expected_chars.pop_front();
                    checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected char %h last %b status %0d, got %h %b %0d",
                                     want.ch, want.last, want.st, got.ch, got.last, got.st);
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_stall <= 1'b1;
            end else if (!tail_mode && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end else
                out_stall <= 1'b0;
        end
    end

    // watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired with %0d char items outstanding",
                         expected_chars.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_max_len(int unsigned v);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_MAXLEN;
        pwdata <= 32'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_len = v;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_chars.size() != 0 || in_valid)
            @(posedge clk);
        repeat (4000) @(posedge clk);
    endtask

    task automatic queue_label(int unsigned len, int unsigned mix);
        int unsigned r;
        point_item_t it;
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < mix) it.cp = CP_W'($urandom_range(0, 127));
            else if (r < 90) it.cp = CP_W'($urandom_range(128, 'h3000));
            else if (r < 97) it.cp = CP_W'($urandom_range(128, 'h10FFFF));
            else it.cp = CP_W'($urandom_range('h10FFFF, 'h1FFFFF));
            it.last = (i == len - 1);
            pending_points.push_back(it);
        end
    endtask

    task automatic queue_points(int unsigned a, int unsigned b, bit last);
        pending_points.push_back('{CP_W'(a), 1'b0});
        pending_points.push_back('{CP_W'(b), last});
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_quiet = 1; tail_mode = 0;
        label_len = 0; label_ovf = 0; max_len = 63;
        mismatches = 0; checked = 0; labels_sent = 0; idle_cycles = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset length, extremes and special cases
        pending_points.push_back('{CP_W'(0), 1'b1});
        pending_points.push_back('{CP_W'(127), 1'b1});
        queue_points('h61, 'h62, 1);
        pending_points.push_back('{CP_W'('h80), 1'b1});
        queue_points('h1FFFFF, 'h10FFFF, 1);
        queue_points('h41, 'hE9, 1);
        queue_points('h1FFFFF, 'h155555, 0);
        pending_points.push_back('{CP_W'('h0AAAAA), 1'b1});
        for (int i = 0; i < 65; i++)
            pending_points.push_back('{CP_W'($urandom_range(0, 'h1FFF)), i == 64});
        in_quiet = 0;
        wait_drained();

        write_max_len(1);
        pending_points.push_back('{CP_W'('h7A), 1'b1});
        queue_points('h78, 'h79, 1);
        queue_points('h4E2D, 'h6587, 1);
        wait_drained();

        write_max_len(0);
        pending_points.push_back('{CP_W'('h41), 1'b1});
        wait_drained();

        // random phases at several lengths; pauses until drained between them
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_max_len(63);
                1: write_max_len($urandom_range(2, 12));
                2: write_max_len($urandom_range(13, 40));
                3: write_max_len(63);
                default: write_max_len(63);
            endcase
            if (ph == 4) tail_mode = 1;
            for (int l = 0; l < 3; l++)
                queue_label($urandom_range(1, 4), $urandom_range(0, 60));
            if (ph == 3) queue_label(64, 30);
            wait_drained();
        end

        $display("covered %0d labels and %0d char items at lengths 0, 1, mid and 63",
                 labels_sent, checked);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pce_pkg.sv
sv/pce_fifo.sv
sv/pce_front.sv
sv/pce_div.sv
sv/pce_back.sv
sv/punycode_label_encoder.sv
dv/punycode_label_encoder_tb.sv
